/* hw/rtl/ptpdc_pkg.sv */
// Shared types, constants and the direction binning function of the
// profile turn-point direction coder. No dependencies.
package ptpdc_pkg;

    localparam int COORD_W = 8;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SLOPE_W = 10;
    localparam int CODE_W  = 3;
    localparam int SIDE_W  = 2;
    localparam int NEAR_LIMIT = 5;
    localparam logic signed [SLOPE_W-1:0] SLOPE_RESET = 10'sd99;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    // Register index is taken from the word address bit.
    localparam logic REG_PROFILE_SIDE = 1'b0;

    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd3;

    localparam logic [CODE_W-1:0] CODE_STEEP_UP   = 3'd0;
    localparam logic [CODE_W-1:0] CODE_DIAG_UP    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SHALLOW_UP = 3'd2;
    localparam logic [CODE_W-1:0] CODE_FLAT       = 3'd3;
    localparam logic [CODE_W-1:0] CODE_SHALLOW_DN = 3'd4;
    localparam logic [CODE_W-1:0] CODE_DIAG_DN    = 3'd5;
    localparam logic [CODE_W-1:0] CODE_STEEP_DN   = 3'd6;
    localparam logic [CODE_W-1:0] CODE_VERT_DN    = 3'd7;

    localparam int QDEPTH = 4;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } result_t;

    typedef struct packed {
        logic    inner_vld;
        result_t inner;
        logic    close_vld;
        result_t close;
    } pair_t;

    // Bins the segment from (r0,c0) to (r1,c1) against tan 22.5, 45 and
    // 67.5 degrees using squared integer compares.
    function automatic logic [CODE_W-1:0] bin_angle(
        input logic [SIDE_W-1:0]  side,
        input logic [COORD_W-1:0] r0,
        input logic [COORD_W-1:0] c0,
        input logic [COORD_W-1:0] r1,
        input logic [COORD_W-1:0] c1
    );
        logic signed [DIFF_W-1:0] dr;
        logic signed [DIFF_W-1:0] dc;
        logic signed [DIFF_W-1:0] num;
        logic signed [DIFF_W-1:0] den;
        logic signed [DIFF_W-1:0] num_abs;
        logic signed [DIFF_W-1:0] den_abs;
        logic [COORD_W-1:0]       a;
        logic [COORD_W-1:0]       b;
        logic [COORD_W-1:0]       d;
        logic [COORD_W:0]         s;
        logic [2*COORD_W-1:0]     bsq;
        logic [2*COORD_W-1:0]     dsq;
        logic [2*COORD_W+1:0]     b2;
        logic [2*COORD_W+1:0]     dsq_x;
        logic [2*COORD_W+1:0]     ssq;
        logic                     pos;
        logic [CODE_W-1:0]        code;
        dr = $signed({1'b0, r1}) - $signed({1'b0, r0});
        dc = $signed({1'b0, c0}) - $signed({1'b0, c1});
        if (side[0] == 1'b0) begin
            num = dr;
            den = dc;
        end else begin
            num = dc;
            den = dr;
        end
        if (side == SIDE_RIGHT) begin
            num = -num;
        end
        pos     = (num > 0) == (den > 0);
        num_abs = (num < 0) ? -num : num;
        den_abs = (den < 0) ? -den : den;
        a       = num_abs[COORD_W-1:0];
        b       = den_abs[COORD_W-1:0];
        d       = (a > b) ? (a - b) : (b - a);
        s       = {1'b0, a} + {1'b0, b};
        bsq     = (2*COORD_W)'(b) * (2*COORD_W)'(b);
        dsq     = (2*COORD_W)'(d) * (2*COORD_W)'(d);
        ssq     = (2*COORD_W+2)'(s) * (2*COORD_W+2)'(s);
        b2      = {1'b0, bsq, 1'b0};
        dsq_x   = {2'b00, dsq};
        if (num == 0) begin
            code = CODE_FLAT;
        end else if (den == 0) begin
            code = CODE_STEEP_UP;
        end else if (pos) begin
            if (a > b && dsq_x > b2) begin
                code = CODE_STEEP_UP;
            end else if (a >= b) begin
                code = CODE_DIAG_UP;
            end else if (ssq > b2) begin
                code = CODE_SHALLOW_UP;
            end else begin
                code = CODE_FLAT;
            end
        end else begin
            if (ssq < b2) begin
                code = CODE_SHALLOW_DN;
            end else if (a <= b) begin
                code = CODE_DIAG_DN;
            end else if (dsq_x < b2) begin
                code = CODE_STEEP_DN;
            end else begin
                code = CODE_VERT_DN;
            end
        end
        return code;
    endfunction

endpackage

/* hw/rtl/ptpdc_keypoint.sv */
// Keypoint decision and profile state: point window, held keypoint and
// last accepted slope pair. Depends on ptpdc_pkg.
module ptpdc_keypoint (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [ptpdc_pkg::COORD_W-1:0] row,
    input  logic [ptpdc_pkg::COORD_W-1:0] col,
    input  logic                          last,
    input  logic [ptpdc_pkg::SIDE_W-1:0]  side,
    output ptpdc_pkg::pair_t              results
);

    logic [ptpdc_pkg::COORD_W-1:0]        win_row_reg [3];
    logic [ptpdc_pkg::COORD_W-1:0]        win_col_reg [3];
    logic [1:0]                           seen_reg;
    logic [ptpdc_pkg::COORD_W-1:0]        key_row_reg;
    logic [ptpdc_pkg::COORD_W-1:0]        key_col_reg;
    logic signed [ptpdc_pkg::SLOPE_W-1:0] slope_a_reg;
    logic signed [ptpdc_pkg::SLOPE_W-1:0] slope_b_reg;

    logic [ptpdc_pkg::COORD_W-1:0]        p0, p1, p2;
    logic signed [ptpdc_pkg::DIFF_W-1:0]  s0, s1;
    logic signed [ptpdc_pkg::DIFF_W-1:0]  near_dr, near_dc;
    logic                                 same_dir;
    logic                                 near_key;
    logic                                 rep_slope;
    logic                                 inner_vld;
    logic [ptpdc_pkg::COORD_W-1:0]        mid_row, mid_col;

    always_comb
    begin
        p0 = side[0] ? win_col_reg[0] : win_row_reg[0];
        p1 = side[0] ? win_col_reg[1] : win_row_reg[1];
        p2 = side[0] ? win_col_reg[2] : win_row_reg[2];
        s0 = $signed({1'b0, p1}) - $signed({1'b0, p0});
        s1 = $signed({1'b0, p2}) - $signed({1'b0, p1});
        same_dir = (s0 > 0 && s1 > 0) || (s0 < 0 && s1 < 0) || (s0 == 0 && s1 == 0);
        near_dr = $signed({1'b0, win_row_reg[1]}) - $signed({1'b0, key_row_reg});
        near_dc = $signed({1'b0, win_col_reg[1]}) - $signed({1'b0, key_col_reg});
        near_key = (near_dr <= $signed(ptpdc_pkg::DIFF_W'(ptpdc_pkg::NEAR_LIMIT)))
                && (near_dc <= $signed(ptpdc_pkg::DIFF_W'(ptpdc_pkg::NEAR_LIMIT)));
        rep_slope = (slope_a_reg == ptpdc_pkg::SLOPE_W'(s0))
                 && (slope_b_reg == ptpdc_pkg::SLOPE_W'(s1));
        inner_vld = (seen_reg == 2'd3) && !same_dir && !near_key && !rep_slope;

        // The keypoint that the closing segment starts from.
        if (inner_vld) begin
            mid_row = win_row_reg[1];
            mid_col = win_col_reg[1];
        end else if (seen_reg == 2'd0) begin
            mid_row = row;
            mid_col = col;
        end else begin
            mid_row = key_row_reg;
            mid_col = key_col_reg;
        end

        results.inner_vld  = inner_vld;
        results.inner.code = ptpdc_pkg::bin_angle(side, key_row_reg, key_col_reg,
                                                  win_row_reg[1], win_col_reg[1]);
        results.inner.row  = win_row_reg[1];
        results.inner.col  = win_col_reg[1];
        results.inner.last = 1'b0;
        results.close_vld  = last;
        results.close.code = ptpdc_pkg::bin_angle(side, mid_row, mid_col, row, col);
        results.close.row  = row;
        results.close.col  = col;
        results.close.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 3; i++) begin
                win_row_reg[i] <= '0;
                win_col_reg[i] <= '0;
            end
            seen_reg    <= '0;
            key_row_reg <= '0;
            key_col_reg <= '0;
            slope_a_reg <= ptpdc_pkg::SLOPE_RESET;
            slope_b_reg <= ptpdc_pkg::SLOPE_RESET;
        end else if (fire) begin
            if (last) begin
                // The final point closes the profile and clears its state.
                for (int i = 0; i < 3; i++) begin
                    win_row_reg[i] <= '0;
                    win_col_reg[i] <= '0;
                end
                seen_reg    <= '0;
                key_row_reg <= '0;
                key_col_reg <= '0;
                slope_a_reg <= ptpdc_pkg::SLOPE_RESET;
                slope_b_reg <= ptpdc_pkg::SLOPE_RESET;
            end else begin
                win_row_reg[0] <= win_row_reg[1];
                win_row_reg[1] <= win_row_reg[2];
                win_row_reg[2] <= row;
                win_col_reg[0] <= win_col_reg[1];
                win_col_reg[1] <= win_col_reg[2];
                win_col_reg[2] <= col;
                if (seen_reg != 2'd3) begin
                    seen_reg <= seen_reg + 2'd1;
                end
                key_row_reg <= mid_row;
                key_col_reg <= mid_col;
                if (inner_vld) begin
                    slope_a_reg <= ptpdc_pkg::SLOPE_W'(s0);
                    slope_b_reg <= ptpdc_pkg::SLOPE_W'(s1);
                end
            end
        end
    end

endmodule

/* hw/rtl/ptpdc_result_fifo.sv */
// Four-entry result queue that takes up to two results per cycle and
// presents its head from a register. Depends on ptpdc_pkg.
module ptpdc_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ptpdc_pkg::pair_t  push_data,
    input  logic              pop,
    output logic              head_valid,
    output ptpdc_pkg::result_t head,
    output logic              room
);

    ptpdc_pkg::result_t             slot_reg  [ptpdc_pkg::QDEPTH];
    ptpdc_pkg::result_t             slot_next [ptpdc_pkg::QDEPTH];
    logic [ptpdc_pkg::QCNT_W-1:0]   count_reg;
    logic [ptpdc_pkg::QCNT_W-1:0]   count_next;
    logic [ptpdc_pkg::QCNT_W-1:0]   base;
    logic [ptpdc_pkg::QCNT_W-1:0]   n_push;

    always_comb
    begin
        base   = count_reg - ptpdc_pkg::QCNT_W'(pop);
        n_push = '0;
        if (push) begin
            n_push = ptpdc_pkg::QCNT_W'(push_data.inner_vld)
                   + ptpdc_pkg::QCNT_W'(push_data.close_vld);
        end
        for (int i = 0; i < ptpdc_pkg::QDEPTH; i++) begin
            if (pop && i < ptpdc_pkg::QDEPTH - 1) begin
                slot_next[i] = slot_reg[i+1];
            end else begin
                slot_next[i] = slot_reg[i];
            end
            if (push) begin
                if (push_data.inner_vld) begin
                    if (ptpdc_pkg::QCNT_W'(i) == base) begin
                        slot_next[i] = push_data.inner;
                    end else if (ptpdc_pkg::QCNT_W'(i) == base + 3'd1
                                 && push_data.close_vld) begin
                        slot_next[i] = push_data.close;
                    end
                end else if (push_data.close_vld && ptpdc_pkg::QCNT_W'(i) == base) begin
                    slot_next[i] = push_data.close;
                end
            end
        end
        count_next = base + n_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ptpdc_pkg::QDEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[0];
    // Space for two results even if nothing leaves this cycle.
    assign room       = (count_reg <= ptpdc_pkg::QCNT_W'(ptpdc_pkg::QDEPTH - 2));

endmodule

/* hw/rtl/profile_turn_point_direction_coder_core.sv */
// Top level of the profile turn-point direction coder: input register,
// profile_side register, keypoint logic and result queue.
// Depends on ptpdc_pkg, ptpdc_keypoint and ptpdc_result_fifo.
//
//  channel  | valid / stall             | payload
//  ---------+---------------------------+-------------------------------------
//  point    | point_valid / point_stall | point_row, point_col, last_point
//  code     | code_valid / code_stall   | direction_code, key_row, key_col,
//           |                           | last_segment
//  config   | APB psel/penable/pwrite   | paddr, pwdata, prdata (profile_side)
//
// One point beat per cycle is sustained while the result queue has room; an
// accepted point waits in the input register until the queue takes its
// results, which leave from the queue head register. A final point may give
// two result beats. Reset clears the profile state, the queue and profile_side.
// point_stall rises only while the input register is held because the
// four-entry result queue cannot take two more results.
module profile_turn_point_direction_coder_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_stall,
    input  logic [ptpdc_pkg::COORD_W-1:0]       point_row,
    input  logic [ptpdc_pkg::COORD_W-1:0]       point_col,
    input  logic                                last_point,
    output logic                                code_valid,
    input  logic                                code_stall,
    output logic [ptpdc_pkg::CODE_W-1:0]        direction_code,
    output logic [ptpdc_pkg::COORD_W-1:0]       key_row,
    output logic [ptpdc_pkg::COORD_W-1:0]       key_col,
    output logic                                last_segment,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptpdc_pkg::ADDR_W-1:0]        paddr,
    input  logic [ptpdc_pkg::DATA_W-1:0]        pwdata,
    output logic [ptpdc_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    logic                            pt_full_reg;
    logic                            pt_full_next;
    logic [ptpdc_pkg::COORD_W-1:0]   pt_row_reg;
    logic [ptpdc_pkg::COORD_W-1:0]   pt_col_reg;
    logic                            pt_last_reg;
    logic [ptpdc_pkg::SIDE_W-1:0]    side_reg;
    logic                            accept;
    logic                            advance;
    logic                            room;
    logic                            pop;
    ptpdc_pkg::pair_t                results;
    ptpdc_pkg::result_t              head;

    assign advance      = pt_full_reg && room;
    assign point_stall  = pt_full_reg && !room;
    assign accept       = point_valid && !point_stall;
    assign pt_full_next = accept ? 1'b1 : (advance ? 1'b0 : pt_full_reg);
    assign pop          = code_valid && !code_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pt_full_reg <= 1'b0;
        end else begin
            pt_full_reg <= pt_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            pt_row_reg  <= point_row;
            pt_col_reg  <= point_col;
            pt_last_reg <= last_point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            side_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ptpdc_pkg::REG_PROFILE_SIDE) begin
            side_reg <= pwdata[ptpdc_pkg::SIDE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ptpdc_pkg::REG_PROFILE_SIDE)
                  ? {{(ptpdc_pkg::DATA_W - ptpdc_pkg::SIDE_W){1'b0}}, side_reg}
                  : '0;

    ptpdc_keypoint u_keypoint (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .row     (pt_row_reg),
        .col     (pt_col_reg),
        .last    (pt_last_reg),
        .side    (side_reg),
        .results (results)
    );

    ptpdc_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (advance),
        .push_data  (results),
        .pop        (pop),
        .head_valid (code_valid),
        .head       (head),
        .room       (room)
    );

    assign direction_code = head.code;
    assign key_row        = head.row;
    assign key_col        = head.col;
    assign last_segment   = head.last;

endmodule

/* hw/rtl/ptpdc_checker.sv */
// Port-level checks for the profile turn-point direction coder, bound to
// the top level. Depends on ptpdc_pkg and the top level's ports.
module ptpdc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                point_valid,
    input logic                                point_stall,
    input logic [ptpdc_pkg::COORD_W-1:0]       point_row,
    input logic [ptpdc_pkg::COORD_W-1:0]       point_col,
    input logic                                last_point,
    input logic                                code_valid,
    input logic                                code_stall,
    input logic [ptpdc_pkg::CODE_W-1:0]        direction_code,
    input logic [ptpdc_pkg::COORD_W-1:0]       key_row,
    input logic [ptpdc_pkg::COORD_W-1:0]       key_col,
    input logic                                last_segment,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [ptpdc_pkg::ADDR_W-1:0]        paddr,
    input logic [ptpdc_pkg::DATA_W-1:0]        pwdata,
    input logic [ptpdc_pkg::DATA_W-1:0]        prdata,
    input logic                                pready
);

    // A held result beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid
            && $stable(direction_code) && $stable(key_row)
            && $stable(key_col) && $stable(last_segment))
        else $error("held result beat changed");

    // A stalled point beat is offered again unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid
            && $stable(point_row) && $stable(point_col) && $stable(last_point))
        else $error("stalled point beat changed");

    // Input back-pressure only comes from queued results.
    assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> code_valid)
        else $error("point stall without pending results");

    // A result never disappears without being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(code_valid) |-> $past(!code_stall))
        else $error("result beat dropped");

    // A write to profile_side is read back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
            && paddr[2] == ptpdc_pkg::REG_PROFILE_SIDE
        |=> (paddr[2] != ptpdc_pkg::REG_PROFILE_SIDE)
            || (prdata[ptpdc_pkg::SIDE_W-1:0] == $past(pwdata[ptpdc_pkg::SIDE_W-1:0])))
        else $error("profile_side readback mismatch");

endmodule

bind profile_turn_point_direction_coder_core ptpdc_checker u_ptpdc_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for profile_turn_point_direction_coder_core: scripted and random
// profiles checked against an in-bench keypoint and direction predictor.
// Depends on ptpdc_pkg and the core RTL.
module tb_top;

    import ptpdc_pkg::*;

    localparam int STUCK_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PRESSURE_AT   = 900;
    localparam int PHASE_ITEMS   = 270;
    localparam int PHASE_COUNT   = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [ADDR_W-1:0] SIDE_ADDR = {REG_PROFILE_SIDE, 2'b00};

    localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               closes;
        logic               typed;
        logic [CODE_W-1:0]  typed_code;
    } scripted_point_t;

    logic                clk;
    logic                rst_n;
    logic                point_valid;
    logic                point_stall;
    logic [COORD_W-1:0]  point_row;
    logic [COORD_W-1:0]  point_col;
    logic                last_point;
    logic                code_valid;
    logic                code_stall;
    logic [CODE_W-1:0]   direction_code;
    logic [COORD_W-1:0]  key_row;
    logic [COORD_W-1:0]  key_col;
    logic                last_segment;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predictor state: a private copy of the profile tracker.
    logic [SIDE_W-1:0]         coder_side;
    logic [COORD_W-1:0]        win_rows [3];
    logic [COORD_W-1:0]        win_cols [3];
    logic [1:0]                pts_held;
    logic [COORD_W-1:0]        anchor_row;
    logic [COORD_W-1:0]        anchor_col;
    logic signed [SLOPE_W-1:0] last_slope_a;
    logic signed [SLOPE_W-1:0] last_slope_b;
    int                        fresh_count;

    result_t         awaited_segments [$];
    scripted_point_t scripted_points [$];

    int fault_count  = 0;
    int points_taken = 0;
    bit steady       = 1'b0;
    bit held_back    = 1'b0;

    profile_turn_point_direction_coder_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .point_valid    (point_valid),
        .point_stall    (point_stall),
        .point_row      (point_row),
        .point_col      (point_col),
        .last_point     (last_point),
        .code_valid     (code_valid),
        .code_stall     (code_stall),
        .direction_code (direction_code),
        .key_row        (key_row),
        .key_col        (key_col),
        .last_segment   (last_segment),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_profile_state();
        for (int i = 0; i < 3; i++)
        begin
            win_rows[i] = '0;
            win_cols[i] = '0;
        end
        pts_held     = '0;
        anchor_row   = '0;
        anchor_col   = '0;
        last_slope_a = SLOPE_RESET;
        last_slope_b = SLOPE_RESET;
    endfunction

    // Bins the segment by comparing the tangent against tan 22.5, 45 and 67.5 degrees,
    // with the irrational bounds squared away so that only integers are involved.
    function automatic logic [CODE_W-1:0] direction_of(
        input logic [COORD_W-1:0] r0,
        input logic [COORD_W-1:0] c0,
        input logic [COORD_W-1:0] r1,
        input logic [COORD_W-1:0] c1
    );
        int   num;
        int   den;
        int   a;
        int   b;
        int   b2;
        logic up;
        if (coder_side[0])
        begin
            num = int'(c0) - int'(c1);
            den = int'(r1) - int'(r0);
        end
        else
        begin
            num = int'(r1) - int'(r0);
            den = int'(c0) - int'(c1);
        end
        if (num == 0)
            return CODE_FLAT;
        if (den == 0)
            return CODE_STEEP_UP;
        if (coder_side == SIDE_RIGHT)
            num = -num;
        up = (num > 0) == (den > 0);
        a  = (num < 0) ? -num : num;
        b  = (den < 0) ? -den : den;
        b2 = 2 * b * b;
        if (up)
        begin
            if (a > b && (a - b) * (a - b) > b2)
                return CODE_STEEP_UP;
            if (a >= b)
                return CODE_DIAG_UP;
            if ((a + b) * (a + b) > b2)
                return CODE_SHALLOW_UP;
            return CODE_FLAT;
        end
        if ((a + b) * (a + b) < b2)
            return CODE_SHALLOW_DN;
        if (a <= b)
            return CODE_DIAG_DN;
        if ((a - b) * (a - b) < b2)
            return CODE_STEEP_DN;
        return CODE_VERT_DN;
    endfunction

    function automatic void close_segment(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c,
        input logic               closes
    );
        result_t seg;
        seg.code = direction_of(anchor_row, anchor_col, r, c);
        seg.row  = r;
        seg.col  = c;
        seg.last = closes;
        awaited_segments.push_back(seg);
        fresh_count++;
        anchor_row = r;
        anchor_col = c;
    endfunction

    // Takes one accepted point and queues the segments it closes.
    function automatic void advance_profile(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c,
        input logic               closes
    );
        logic [COORD_W-1:0]        p0;
        logic [COORD_W-1:0]        p1;
        logic [COORD_W-1:0]        p2;
        logic signed [SLOPE_W-1:0] s0;
        logic signed [SLOPE_W-1:0] s1;
        logic                      same;
        logic                      near;
        logic                      repeated;
        fresh_count = 0;
        if (pts_held == 2'd0)
        begin
            anchor_row = r;
            anchor_col = c;
        end
        else if (pts_held == 2'd3)
        begin
            p0   = coder_side[0] ? win_cols[0] : win_rows[0];
            p1   = coder_side[0] ? win_cols[1] : win_rows[1];
            p2   = coder_side[0] ? win_cols[2] : win_rows[2];
            s0   = $signed(SLOPE_W'(p1)) - $signed(SLOPE_W'(p0));
            s1   = $signed(SLOPE_W'(p2)) - $signed(SLOPE_W'(p1));
            same = (s0 > 0 && s1 > 0) || (s0 < 0 && s1 < 0) || (s0 == 0 && s1 == 0);
            if (!same)
            begin
                // The middle point of the window is the candidate turn point.
                near = (int'(win_cols[1]) - int'(anchor_col) <= NEAR_LIMIT) &&
                       (int'(win_rows[1]) - int'(anchor_row) <= NEAR_LIMIT);
                repeated = (last_slope_a == s0) && (last_slope_b == s1);
                if (!near && !repeated)
                begin
                    last_slope_a = s0;
                    last_slope_b = s1;
                    close_segment(win_rows[1], win_cols[1], 1'b0);
                end
            end
        end
        win_rows[0] = win_rows[1];
        win_rows[1] = win_rows[2];
        win_rows[2] = r;
        win_cols[0] = win_cols[1];
        win_cols[1] = win_cols[2];
        win_cols[2] = c;
        if (pts_held != 2'd3)
            pts_held = pts_held + 2'd1;
        if (closes)
        begin
            close_segment(r, c, 1'b1);
            clear_profile_state();
        end
    endfunction

    function automatic void script(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c,
        input logic               closes,
        input logic               typed,
        input logic [CODE_W-1:0]  code
    );
        scripted_point_t entry;
        entry.row        = r;
        entry.col        = c;
        entry.closes     = closes;
        entry.typed      = typed;
        entry.typed_code = code;
        scripted_points.push_back(entry);
    endfunction

    task automatic offer_point(
        input logic [COORD_W-1:0] r,
        input logic [COORD_W-1:0] c,
        input logic               closes
    );
        while (!steady && $urandom_range(0, 99) < 25)
        begin
            point_valid <= 1'b0;
            @(posedge clk);
        end
        point_valid <= 1'b1;
        point_row   <= r;
        point_col   <= c;
        last_point  <= closes;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        points_taken++;
        advance_profile(r, c, closes);
    endtask

    // The register is only written once every awaited segment is out and the
    // pipeline has had time to swallow points that close nothing.
    task automatic settle_and_set_side(input logic [SIDE_W-1:0] new_side);
        point_valid <= 1'b0;
        while (awaited_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIDE_ADDR;
        pwdata  <= ($urandom() & ~DATA_W'(3)) | DATA_W'(new_side);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        coder_side = new_side;
    endtask

    initial
    begin
        int                phase;
        int                issued;
        int                len;
        int                pick;
        int                r;
        int                c;
        int                rdir;
        int                cdir;
        int                step;
        logic [SIDE_W-1:0] phase_side;
        rst_n       <= 1'b0;
        point_valid <= 1'b0;
        point_row   <= '0;
        point_col   <= '0;
        last_point  <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        coder_side = SIDE_TOP;
        clear_profile_state();

        // Single-point and two-point profiles, whose codes can be read off directly.
        script(8'd0,   8'd0,   1'b1, 1'b1, CODE_FLAT);
        script(8'd255, 8'd255, 1'b1, 1'b1, CODE_FLAT);
        script(8'd0,   8'd0,   1'b0, 1'b1, CODE_FLAT);
        script(8'd255, 8'd0,   1'b1, 1'b1, CODE_STEEP_UP);
        script(8'd0,   8'd255, 1'b0, 1'b1, CODE_FLAT);
        script(8'd0,   8'd0,   1'b1, 1'b1, CODE_FLAT);
        script(8'd255, 8'd0,   1'b0, 1'b1, CODE_FLAT);
        script(8'd0,   8'd255, 1'b1, 1'b1, CODE_DIAG_UP);
        script(8'd0,   8'd0,   1'b0, 1'b1, CODE_FLAT);
        script(8'd255, 8'd255, 1'b1, 1'b1, CODE_DIAG_DN);
        // A turn judged on the final point, giving two segments in one step.
        script(8'd10,  8'd10,  1'b0, 1'b0, CODE_FLAT);
        script(8'd100, 8'd20,  1'b0, 1'b0, CODE_FLAT);
        script(8'd50,  8'd30,  1'b0, 1'b0, CODE_FLAT);
        script(8'd0,   8'd40,  1'b1, 1'b0, CODE_FLAT);
        // Zigzag with one turn close to the keypoint and one repeating the slope pair.
        script(8'd0,   8'd0,   1'b0, 1'b0, CODE_FLAT);
        script(8'd50,  8'd10,  1'b0, 1'b0, CODE_FLAT);
        script(8'd0,   8'd12,  1'b0, 1'b0, CODE_FLAT);
        script(8'd50,  8'd20,  1'b0, 1'b0, CODE_FLAT);
        script(8'd0,   8'd30,  1'b0, 1'b0, CODE_FLAT);
        script(8'd20,  8'd40,  1'b1, 1'b0, CODE_FLAT);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        settle_and_set_side(SIDE_TOP);
        foreach (scripted_points[i])
        begin
            offer_point(scripted_points[i].row, scripted_points[i].col,
                        scripted_points[i].closes);
            if (scripted_points[i].typed)
            begin
                repeat (fresh_count) void'(awaited_segments.pop_back());
                if (scripted_points[i].closes)
                    awaited_segments.push_back('{code: scripted_points[i].typed_code,
                                                 row:  scripted_points[i].row,
                                                 col:  scripted_points[i].col,
                                                 last: 1'b1});
            end
        end

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       phase_side = SIDE_RIGHT;
                1:       phase_side = SIDE_LEFT;
                2:       phase_side = SIDE_BOTTOM;
                3:       phase_side = SIDE_TOP;
                default: phase_side = SIDE_W'($urandom_range(0, 3));
            endcase
            settle_and_set_side(phase_side);
            steady = (phase == 2);
            issued = 0;
            while (issued < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = $urandom_range(1, 2);
                else if (pick < 90)
                    len = $urandom_range(3, 20);
                else
                    len = $urandom_range(30, 60);
                r    = $urandom_range(0, 255);
                c    = $urandom_range(0, 255);
                rdir = $urandom_range(0, 1) ? 1 : -1;
                cdir = $urandom_range(0, 1) ? 1 : -1;
                for (int i = 0; i < len; i++)
                begin
                    // Mostly a wandering outline, now and then a point out of nowhere.
                    if ($urandom_range(0, 99) < 15)
                    begin
                        r = $urandom_range(0, 255);
                        c = $urandom_range(0, 255);
                    end
                    else if (i > 0)
                    begin
                        if ($urandom_range(0, 99) < 30)
                            rdir = -rdir;
                        if ($urandom_range(0, 99) < 30)
                            cdir = -cdir;
                        step = $urandom_range(0, 40);
                        r    = r + rdir * step;
                        step = $urandom_range(0, 40);
                        c    = c + cdir * step;
                        r    = (r < 0) ? 0 : (r > 255) ? 255 : r;
                        c    = (c < 0) ? 0 : (c > 255) ? 255 : c;
                    end
                    offer_point(COORD_W'(r), COORD_W'(c), i == len - 1);
                end
                issued += len;
            end
            steady = 1'b0;
        end

        point_valid <= 1'b0;
        while (awaited_segments.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && awaited_segments.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Segment receiver: random back-pressure, one long hold-off to fill the core.
    initial
    begin
        result_t seen;
        result_t want;
        int      hold_left;
        hold_left = 0;
        code_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (code_valid && !code_stall)
            begin
                seen.code = direction_code;
                seen.row  = key_row;
                seen.col  = key_col;
                seen.last = last_segment;
                if (awaited_segments.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("unexpected segment: code %0d key (%0d,%0d) last %0d",
                                 seen.code, seen.row, seen.col, seen.last);
                end
                else
                begin
                    want = awaited_segments.pop_front();
                    if (want.code !== seen.code || want.row !== seen.row ||
                        want.col !== seen.col || want.last !== seen.last)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display({"segment mismatch: expected code %0d key (%0d,%0d) ",
                                      "last %0d, got code %0d key (%0d,%0d) last %0d"},
                                     want.code, want.row, want.col, want.last,
                                     seen.code, seen.row, seen.col, seen.last);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                code_stall <= 1'b1;
            end
            else if (!held_back && points_taken >= PRESSURE_AT)
            begin
                held_back = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                code_stall <= 1'b1;
            end
            else
                code_stall <= !steady && ($urandom_range(0, 99) < 25);
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    initial
    begin
        int stuck;
        stuck = 0;
        @(posedge rst_n);
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((point_valid && !point_stall) || (code_valid && !code_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule
